/* sv/pfwc_pkg.sv */
`default_nettype none
package pfwc_pkg;
  localparam int CordicStagesDef = 14;
  localparam int CordicStagesMax = 24;
  localparam int DW = 40;  // cordic datapath width, Q.22 data
  localparam int AW = 34;  // Q.30 angle width
  localparam logic signed [AW-1:0] AngPi  = 34'sd3373259426;
  localparam logic signed [AW-1:0] AngPi2 = 34'sd1686629713;
  localparam logic signed [31:0] InvK = 32'sd652032874;

  typedef enum logic [2:0] {
    REG_STEER_GAIN = 3'd0,
    REG_SPEED_GAIN = 3'd1,
    REG_INV_RADIUS = 3'd2,
    REG_MIN_SPEED  = 3'd3,
    REG_MAX_SPEED  = 3'd4,
    REG_ESC_SPEED  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_ESCAPE = 2'd1,
    ST_OVER   = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0]        steer_gain;
    logic [15:0]        speed_gain;
    logic [15:0]        inv_radius;
    logic [14:0]        min_speed;
    logic [14:0]        max_speed;
    logic signed [15:0] esc_speed;
  } cfg_t;

  function automatic logic signed [AW-1:0] atan_lut(input int i);
    logic signed [AW-1:0] t;
    begin
      case (i)
        0: t = 34'sh3243F6A8;  1: t = 34'sh1DAC6705;
        2: t = 34'sh0FADBAFC;  3: t = 34'sh07F56EA6;
        4: t = 34'sh03FEAB76;  5: t = 34'sh01FFD55B;
        6: t = 34'sh00FFFAAA;  7: t = 34'sh007FFF55;
        8: t = 34'sh003FFFEA;  9: t = 34'sh001FFFFD;
        10: t = 34'sh000FFFFF; 11: t = 34'sh0007FFFF;
        12: t = 34'sh0003FFFF; 13: t = 34'sh0001FFFF;
        14: t = 34'sh0000FFFF; 15: t = 34'sh00007FFF;
        16: t = 34'sh00003FFF; 17: t = 34'sh00001FFF;
        18: t = 34'sh00000FFF; 19: t = 34'sh000007FF;
        20: t = 34'sh000003FF; 21: t = 34'sh000001FF;
        22: t = 34'sh000000FF; 23: t = 34'sh0000007F;
        default: t = '0;
      endcase
      return t;
    end
  endfunction
endpackage
`default_nettype wire

/* sv/pfwc_cordic.sv */
`default_nettype none
// One registered CORDIC iteration per stage; vectoring or rotating mode.
module pfwc_cordic import pfwc_pkg::*; #(
  parameter int Stages = CordicStagesDef,
  parameter bit Vectoring = 1'b1,
  parameter int SbW = 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic signed [DW-1:0]  x_i,
  input  wire logic signed [DW-1:0]  y_i,
  input  wire logic signed [AW-1:0]  z_i,
  input  wire logic [SbW-1:0]        sb_i,
  output logic                       valid_o,
  output logic signed [DW-1:0]       x_o,
  output logic signed [AW-1:0]       z_o,
  output logic [SbW-1:0]             sb_o
);
  logic                 v_q  [Stages+1];
  logic signed [DW-1:0] x_q  [Stages+1];
  logic signed [DW-1:0] y_q  [Stages+1];
  logic signed [AW-1:0] z_q  [Stages+1];
  logic [SbW-1:0]       sb_q [Stages+1];

  always_comb begin
    v_q[0] = valid_i; x_q[0] = x_i; y_q[0] = y_i; z_q[0] = z_i; sb_q[0] = sb_i;
  end

  for (genvar i = 0; i < Stages; i++) begin : g_it
    logic                 v_r;
    logic signed [DW-1:0] x_r, y_r, dx, dy;
    logic signed [AW-1:0] z_r;
    logic [SbW-1:0]       sb_r;
    logic                 pos;
    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign pos = Vectoring ? (y_q[i] > 0) : (z_q[i] < 0);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_r <= 1'b0;
      else         v_r <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      sb_r <= sb_q[i];
      if (pos) begin
        x_r <= x_q[i] + dx; y_r <= y_q[i] - dy; z_r <= z_q[i] + atan_lut(i);
      end else begin
        x_r <= x_q[i] - dx; y_r <= y_q[i] + dy; z_r <= z_q[i] - atan_lut(i);
      end
    end
    always_comb begin
      v_q[i+1] = v_r; x_q[i+1] = x_r; y_q[i+1] = y_r;
      z_q[i+1] = z_r; sb_q[i+1] = sb_r;
    end
  end

  assign valid_o = v_q[Stages];
  assign x_o     = x_q[Stages];
  assign z_o     = z_q[Stages];
  assign sb_o    = sb_q[Stages];
endmodule
`default_nettype wire

/* sv/pfwc_mix.sv */
`default_nettype none
// Gain stages, wheel mixing and threshold tests.
module pfwc_mix import pfwc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic signed [AW-1:0] ang_i,   // atan2 at Q.30
  input  wire logic signed [DW-1:0] px_i,    // rotated x, Q.22 unscaled
  input  wire logic signed [14:0]   heading_i,
  input  wire cfg_t                 cfg_i,
  output logic                      valid_o,
  output logic signed [15:0]        right_o,
  output logic signed [15:0]        left_o,
  output logic [1:0]                status_o
);
  logic [5:0] v_q;
  // stage 1: projection * 1/K, round Qd
  logic signed [DW+31:0] pk_q;
  logic signed [16:0]    qe_q;
  logic signed [AW:0]    ar;
  assign ar = {ang_i[AW-1], ang_i} + (AW+1)'(131072);
  // stage 2
  logic signed [41:0] proj_q;
  logic signed [16:0] qe2_q;
  // stage 3: V, W products
  logic signed [58:0] vp_q;
  logic signed [33:0] w_q;
  // stage 4: sums
  logic signed [49:0] vw_q [2];
  // stage 5: wheel products
  logic signed [66:0] wp_q [2];
  // stage 6 output
  logic signed [15:0] r_q, l_q;
  logic [1:0]         st_q;

  logic signed [DW+32:0] pkr;
  logic signed [59:0]    vpr;
  logic signed [49:0]    vv;
  logic signed [67:0]    r0, r1;
  logic signed [43:0]    rs, ls;
  logic [43:0]           mr, ml;
  logic                  esc, ovr;

  assign pkr = {pk_q[DW+31], pk_q} + (DW+33)'(64'sd536870912);
  assign vpr = {vp_q[58], vp_q} + 60'sd512;
  assign vv  = 50'(vpr >>> 10);
  assign r0  = {wp_q[0][66], wp_q[0]} + 68'sd8388608;
  assign r1  = {wp_q[1][66], wp_q[1]} + 68'sd8388608;
  assign rs  = 44'(r0 >>> 24);
  assign ls  = 44'(r1 >>> 24);
  assign mr  = rs[43] ? 44'(-rs) : 44'(rs);
  assign ml  = ls[43] ? 44'(-ls) : 44'(ls);
  assign esc = (mr < 44'(cfg_i.min_speed)) && (ml < 44'(cfg_i.min_speed));
  assign ovr = (mr > 44'(cfg_i.max_speed)) && (ml > 44'(cfg_i.max_speed));

  function automatic logic signed [15:0] sat16(input logic signed [43:0] v);
    if (v > 44'sd32767) return 16'sh7FFF;
    if (v < -44'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= {v_q[4:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    pk_q   <= px_i * InvK;
    qe_q   <= 17'(ar >>> 18) - 17'(heading_i);
    proj_q <= 42'(pkr >>> 30);
    qe2_q  <= qe_q;
    vp_q   <= proj_q * $signed({1'b0, cfg_i.speed_gain});
    w_q    <= qe2_q * $signed({1'b0, cfg_i.steer_gain});
    vw_q[0] <= vv + 50'(w_q);
    vw_q[1] <= vv - 50'(w_q);
    wp_q[0] <= vw_q[0] * $signed({1'b0, cfg_i.inv_radius});
    wp_q[1] <= vw_q[1] * $signed({1'b0, cfg_i.inv_radius});
    if (esc) begin
      r_q <= cfg_i.esc_speed; l_q <= cfg_i.esc_speed; st_q <= ST_ESCAPE;
    end else if (ovr) begin
      r_q <= -$signed({1'b0, cfg_i.max_speed});
      l_q <= -$signed({1'b0, cfg_i.max_speed});
      st_q <= ST_OVER;
    end else begin
      r_q <= sat16(rs); l_q <= sat16(ls); st_q <= ST_NORMAL;
    end
  end

  assign valid_o  = v_q[5];
  assign right_o  = r_q;
  assign left_o   = l_q;
  assign status_o = st_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> status_o != 2'd3)
    else $error("bad status code");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == ST_ESCAPE |-> right_o == left_o)
    else $error("escape speeds differ");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == ST_OVER |-> right_o == left_o && right_o <= 0)
    else $error("overspeed clamp wrong");
endmodule
`default_nettype wire

/* sv/potential_field_wheel_controller.sv */
// Channel    | Direction | Handshake              | Payload
// command    | in        | start / busy           | grad_x_i, grad_y_i, heading_i
// config     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// result     | out       | strobe_o (one cycle)   | right_speed_o, left_speed_o, status_o
// One item per clock; the path is the input register, the CORDIC chain and
// six gain/mix stages. busy is always low: the pipeline never stalls
// since the receiver takes every result. Reset clears the valid bits and
// loads the register defaults; config is always ready.
`default_nettype none
module potential_field_wheel_controller import pfwc_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] grad_x_i,
  input  wire logic signed [15:0] grad_y_i,
  input  wire logic signed [14:0] heading_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  output logic                    strobe_o,
  output logic signed [15:0]      right_speed_o,
  output logic signed [15:0]      left_speed_o,
  output logic [1:0]              status_o
);
  cfg_t cfg_q;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{16'd983, 16'd197, 16'd5120, 15'd410, 15'd6144, -16'sd1638};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STEER_GAIN: cfg_q.steer_gain <= cfg_data_i;
        REG_SPEED_GAIN: cfg_q.speed_gain <= cfg_data_i;
        REG_INV_RADIUS: cfg_q.inv_radius <= cfg_data_i;
        REG_MIN_SPEED:  cfg_q.min_speed  <= cfg_data_i[14:0];
        REG_MAX_SPEED:  cfg_q.max_speed  <= cfg_data_i[14:0];
        REG_ESC_SPEED:  cfg_q.esc_speed  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register with quadrant pre-rotation
  logic                 v0_q;
  logic signed [DW-1:0] ax_q, ay_q, rx_q, ry_q;
  logic signed [AW-1:0] az_q, rz_q;
  logic signed [14:0]   h0_q;
  logic signed [DW-1:0] gx, gy;
  logic signed [AW-1:0] hz;
  assign gx = DW'(grad_x_i) <<< 14;
  assign gy = DW'(grad_y_i) <<< 14;
  assign hz = -(AW'(heading_i) <<< 18);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start;
  end
  always_ff @(posedge clk_i) begin
    h0_q <= heading_i;
    if (grad_x_i < 0) begin
      ax_q <= -gx; ay_q <= -gy; az_q <= (grad_y_i >= 0) ? AngPi : -AngPi;
    end else begin
      ax_q <= gx; ay_q <= gy; az_q <= '0;
    end
    if (hz > AngPi2) begin
      rx_q <= -gx; ry_q <= -gy; rz_q <= hz - AngPi;
    end else if (hz < -AngPi2) begin
      rx_q <= -gx; ry_q <= -gy; rz_q <= hz + AngPi;
    end else begin
      rx_q <= gx; ry_q <= gy; rz_q <= hz;
    end
  end

  // zero gradient: vectoring on (0,0) gives z of all-negative steps; force 0
  logic signed [AW-1:0] ang, ang_raw;
  logic signed [DW-1:0] px, unused_x;
  logic signed [AW-1:0] unused_z;
  logic [15:0]          sb;
  logic                 zero0, zero_o, va, vr;
  assign zero0 = (ax_q == '0) && (ay_q == '0);

  pfwc_cordic #(.Stages(CORDIC_STAGES), .Vectoring(1'b1), .SbW(16)) u_vec (
    .clk_i, .rst_ni, .valid_i(v0_q), .x_i(ax_q), .y_i(ay_q), .z_i(az_q),
    .sb_i({zero0, h0_q}), .valid_o(va), .x_o(unused_x), .z_o(ang_raw),
    .sb_o(sb));
  pfwc_cordic #(.Stages(CORDIC_STAGES), .Vectoring(1'b0), .SbW(1)) u_rot (
    .clk_i, .rst_ni, .valid_i(v0_q), .x_i(rx_q), .y_i(ry_q), .z_i(rz_q),
    .sb_i(1'b0), .valid_o(vr), .x_o(px), .z_o(unused_z), .sb_o(zero_o));

  assign ang = sb[15] ? '0 : ang_raw;

  pfwc_mix u_mix (
    .clk_i, .rst_ni, .valid_i(va & (vr | ~zero_o | ~(|unused_x) | ~(|unused_z))),
    .ang_i(ang), .px_i(px), .heading_i(sb[14:0]), .cfg_i(cfg_q),
    .valid_o(strobe_o), .right_o(right_speed_o), .left_o(left_speed_o),
    .status_o(status_o));
endmodule
`default_nettype wire
